[rtl/wdg_pkg.sv]
package wdg_pkg;

  localparam int unsigned CHANNELS    = 8;
  localparam int unsigned COUNT_WIDTH = 32;

  localparam int unsigned CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned CNT_W     = COUNT_WIDTH;
  localparam int unsigned TIMEOUT_W = 31;
  localparam int unsigned CHAN_W    = 3;
  localparam int unsigned ELAPSED_W = 32;
  localparam int unsigned CMP_W     = (CNT_W > TIMEOUT_W) ? CNT_W : TIMEOUT_W;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(2000);

  typedef enum logic {
    REQ_TICK = 1'b0,
    REQ_KICK = 1'b1
  } req_type_e;

  // Result of one pass over the stamp memory
  typedef struct packed {
    logic             done;
    logic [CH_W-1:0]  idx;
    logic [CNT_W-1:0] elapsed;
  } scan_res_t;

  // Elapsed ticks clamped to the 32-bit output field
  function automatic logic [ELAPSED_W-1:0] sat_elapsed(input logic [CNT_W-1:0] el);
    logic [63:0] ext;
    ext = 64'(el);
    return (ext > 64'h0000_0000_FFFF_FFFF) ? '1 : ext[ELAPSED_W-1:0];
  endfunction

endpackage

[rtl/wdg_if.sv]
interface wdg_req_if;
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic [wdg_pkg::CHAN_W-1:0] channel;

  modport source (output valid, req_type, channel, input ready);
  modport sink   (input valid, req_type, channel, output ready);
endinterface

interface wdg_res_if;
  logic                          valid;
  logic                          ready;
  logic                          expired;
  logic [wdg_pkg::CHAN_W-1:0]    oldest_channel;
  logic [wdg_pkg::ELAPSED_W-1:0] oldest_elapsed;

  modport source (output valid, expired, oldest_channel, oldest_elapsed, input ready);
  modport sink   (input valid, expired, oldest_channel, oldest_elapsed, output ready);
endinterface

interface wdg_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [wdg_pkg::TIMEOUT_W-1:0] timeout_ticks;

  modport source (output valid, timeout_ticks, input ready);
  modport sink   (input valid, timeout_ticks, output ready);
endinterface

[rtl/wdg_ram.sv]
module wdg_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/wdg_scan.sv]
module wdg_scan (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [wdg_pkg::CNT_W-1:0]         count_i,
  input  logic [wdg_pkg::CNT_W-1:0]         rdata_i,
  input  logic [wdg_pkg::CHANNELS-1:0]      stamp_vld_i,
  output logic                              rd_en_o,
  output logic [wdg_pkg::CH_W-1:0]          rd_addr_o,
  output wdg_pkg::scan_res_t                res_o
);

  localparam logic [wdg_pkg::CH_W-1:0] LastIdx = wdg_pkg::CH_W'(wdg_pkg::CHANNELS - 1);

  logic                        busy_q;
  logic [wdg_pkg::CH_W-1:0]    rd_idx_q;
  logic                        cmp_vld_q;
  logic                        cmp_last_q;
  logic [wdg_pkg::CH_W-1:0]    cmp_idx_q;
  logic                        done_q;
  logic [wdg_pkg::CH_W-1:0]    best_idx_q;
  logic [wdg_pkg::CNT_W-1:0]   best_el_q;
  logic [wdg_pkg::CNT_W-1:0]   stamp;
  logic [wdg_pkg::CNT_W-1:0]   el;
  logic                        take;

  assign rd_en_o   = busy_q;
  assign rd_addr_o = rd_idx_q;

  // Entries never kicked read as zero
  assign stamp = stamp_vld_i[cmp_idx_q] ? rdata_i : '0;
  assign el    = count_i - stamp;
  assign take  = (cmp_idx_q == '0) || (el > best_el_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      rd_idx_q   <= '0;
      cmp_vld_q  <= 1'b0;
      cmp_last_q <= 1'b0;
      cmp_idx_q  <= '0;
      done_q     <= 1'b0;
    end else begin
      cmp_vld_q  <= busy_q;
      cmp_last_q <= busy_q && (rd_idx_q == LastIdx);
      cmp_idx_q  <= rd_idx_q;
      done_q     <= cmp_vld_q && cmp_last_q;
      if (start_i) begin
        busy_q   <= 1'b1;
        rd_idx_q <= '0;
      end else if (busy_q) begin
        if (rd_idx_q == LastIdx) begin
          busy_q <= 1'b0;
        end
        rd_idx_q <= rd_idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmp_vld_q && take) begin
      best_idx_q <= cmp_idx_q;
      best_el_q  <= el;
    end
  end

  assign res_o.done    = done_q;
  assign res_o.idx     = best_idx_q;
  assign res_o.elapsed = best_el_q;

endmodule

[rtl/multi_channel_liveness_watchdog_core.sv]
// Liveness watchdog over wdg_pkg::CHANNELS clients. A tick item advances a free-running,
// wrapping count; a kick item stamps its channel with the current count. Each item returns
// one result: the channel whose last kick is oldest (lowest index on a tie) and the ticks
// since that kick. Once that figure exceeds timeout_ticks the expiry, culprit and its
// elapsed ticks latch and the count and stamps freeze; later items return the latched
// result. The stamps live in a single-port-read RAM, so an item is handled in steps:
// apply the item, one RAM read per channel, one compare stage, one step to finish the
// pass, and a check that tests the timeout and loads the result register. After expiry
// an item goes straight to the check with no pass over the stamps. A new item is taken
// while a result still waits; the check then holds until the waiting result is taken.
module multi_channel_liveness_watchdog_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  wdg_req_if.sink   req_i,
  wdg_res_if.source res_o,
  wdg_cfg_if.sink   cfg_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHECK
  } state_e;

  state_e                             state_q;
  logic [wdg_pkg::TIMEOUT_W-1:0]      timeout_q;
  logic [wdg_pkg::CNT_W-1:0]          count_q;
  logic [wdg_pkg::CHANNELS-1:0]       stamp_vld_q;
  logic                               expired_q;
  logic [wdg_pkg::CH_W-1:0]           culprit_idx_q;
  logic [wdg_pkg::CNT_W-1:0]          culprit_el_q;
  logic                               res_valid_q;
  logic                               res_expired_q;
  logic [wdg_pkg::CHAN_W-1:0]         res_channel_q;
  logic [wdg_pkg::ELAPSED_W-1:0]      res_elapsed_q;

  logic                               accept;
  logic                               is_kick;
  logic                               kick_in_range;
  logic                               ram_we;
  logic [wdg_pkg::CH_W-1:0]           kick_addr;
  logic                               scan_start;
  logic                               rd_en;
  logic [wdg_pkg::CH_W-1:0]           rd_addr;
  logic [wdg_pkg::CNT_W-1:0]          rdata;
  wdg_pkg::scan_res_t                 scan_res;
  logic                               out_free;
  logic                               over;

  assign req_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign accept      = req_i.valid && req_i.ready;

  assign is_kick       = (req_i.req_type == wdg_pkg::REQ_KICK);
  assign kick_in_range = (32'(req_i.channel) < 32'(wdg_pkg::CHANNELS));
  assign kick_addr     = wdg_pkg::CH_W'(req_i.channel);
  assign ram_we        = accept && !expired_q && is_kick && kick_in_range;
  assign scan_start    = accept && !expired_q;

  assign out_free = !res_valid_q || res_o.ready;
  assign over     = wdg_pkg::CMP_W'(scan_res.elapsed) > wdg_pkg::CMP_W'(timeout_q);

  wdg_ram #(
    .WIDTH (wdg_pkg::CNT_W),
    .DEPTH (wdg_pkg::CHANNELS)
  ) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (kick_addr),
    .wdata_i (count_q),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  wdg_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (scan_start),
    .count_i     (count_q),
    .rdata_i     (rdata),
    .stamp_vld_i (stamp_vld_q),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .res_o       (scan_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      timeout_q     <= wdg_pkg::TIMEOUT_RESET;
      count_q       <= '0;
      stamp_vld_q   <= '0;
      expired_q     <= 1'b0;
      culprit_idx_q <= '0;
      culprit_el_q  <= '0;
      res_valid_q   <= 1'b0;
      res_expired_q <= 1'b0;
      res_channel_q <= '0;
      res_elapsed_q <= '0;
    end else begin
      if (cfg_i.valid) begin
        timeout_q <= cfg_i.timeout_ticks;
      end
      // in check a taken result is replaced by the next one below
      if (res_valid_q && res_o.ready && (state_q != ST_CHECK)) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (expired_q) begin
              state_q <= ST_CHECK;
            end else begin
              if (!is_kick) begin
                count_q <= count_q + 1'b1;
              end
              if (ram_we) begin
                stamp_vld_q[kick_addr] <= 1'b1;
              end
              state_q <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (scan_res.done) begin
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (out_free) begin
            res_valid_q <= 1'b1;
            if (expired_q) begin
              res_expired_q <= 1'b1;
              res_channel_q <= wdg_pkg::CHAN_W'(culprit_idx_q);
              res_elapsed_q <= wdg_pkg::sat_elapsed(culprit_el_q);
            end else begin
              if (over) begin
                expired_q     <= 1'b1;
                culprit_idx_q <= scan_res.idx;
                culprit_el_q  <= scan_res.elapsed;
              end
              res_expired_q <= over;
              res_channel_q <= wdg_pkg::CHAN_W'(scan_res.idx);
              res_elapsed_q <= wdg_pkg::sat_elapsed(scan_res.elapsed);
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign res_o.valid          = res_valid_q;
  assign res_o.expired        = res_expired_q;
  assign res_o.oldest_channel = res_channel_q;
  assign res_o.oldest_elapsed = res_elapsed_q;

  a_expired_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    expired_q |=> expired_q)
    else $error("expiry flag cleared");

  a_frozen_after_expiry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    expired_q |=> ($stable(count_q) && $stable(stamp_vld_q) && $stable(culprit_el_q)))
    else $error("state changed after expiry");

  a_result_from_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> $past(state_q == ST_CHECK))
    else $error("result loaded outside check");

  a_expired_result_latched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_expired_q) |-> expired_q)
    else $error("expired result without latched expiry");

endmodule
